>>> hdl/ldp_pkg.sv
`timescale 1ns / 1ps
package ldp_pkg;

  localparam logic [5:0]  MAX_ORDER = 6'd63;
  localparam logic [63:0] ONE_Q40   = 64'h0000_0100_0000_0000;
  localparam logic [5:0]  SHIFT_X   = 6'd30;
  localparam logic [5:0]  SHIFT_R   = 6'd48;
  localparam longint unsigned ONE_Q48 = 64'h0001_0000_0000_0000;

  // 2^48 / k rounded half up, unsigned Q1.48; orders 0 and 1 never index it
  localparam logic [48:0] RECIP_ROM [64] = '{
    49'd0, 49'(ONE_Q48), 49'((ONE_Q48 + 1) / 2), 49'((ONE_Q48 + 1) / 3),
    49'((ONE_Q48 + 2) / 4), 49'((ONE_Q48 + 2) / 5), 49'((ONE_Q48 + 3) / 6),
    49'((ONE_Q48 + 3) / 7), 49'((ONE_Q48 + 4) / 8), 49'((ONE_Q48 + 4) / 9),
    49'((ONE_Q48 + 5) / 10), 49'((ONE_Q48 + 5) / 11), 49'((ONE_Q48 + 6) / 12),
    49'((ONE_Q48 + 6) / 13), 49'((ONE_Q48 + 7) / 14), 49'((ONE_Q48 + 7) / 15),
    49'((ONE_Q48 + 8) / 16), 49'((ONE_Q48 + 8) / 17), 49'((ONE_Q48 + 9) / 18),
    49'((ONE_Q48 + 9) / 19), 49'((ONE_Q48 + 10) / 20), 49'((ONE_Q48 + 10) / 21),
    49'((ONE_Q48 + 11) / 22), 49'((ONE_Q48 + 11) / 23), 49'((ONE_Q48 + 12) / 24),
    49'((ONE_Q48 + 12) / 25), 49'((ONE_Q48 + 13) / 26), 49'((ONE_Q48 + 13) / 27),
    49'((ONE_Q48 + 14) / 28), 49'((ONE_Q48 + 14) / 29), 49'((ONE_Q48 + 15) / 30),
    49'((ONE_Q48 + 15) / 31), 49'((ONE_Q48 + 16) / 32), 49'((ONE_Q48 + 16) / 33),
    49'((ONE_Q48 + 17) / 34), 49'((ONE_Q48 + 17) / 35), 49'((ONE_Q48 + 18) / 36),
    49'((ONE_Q48 + 18) / 37), 49'((ONE_Q48 + 19) / 38), 49'((ONE_Q48 + 19) / 39),
    49'((ONE_Q48 + 20) / 40), 49'((ONE_Q48 + 20) / 41), 49'((ONE_Q48 + 21) / 42),
    49'((ONE_Q48 + 21) / 43), 49'((ONE_Q48 + 22) / 44), 49'((ONE_Q48 + 22) / 45),
    49'((ONE_Q48 + 23) / 46), 49'((ONE_Q48 + 23) / 47), 49'((ONE_Q48 + 24) / 48),
    49'((ONE_Q48 + 24) / 49), 49'((ONE_Q48 + 25) / 50), 49'((ONE_Q48 + 25) / 51),
    49'((ONE_Q48 + 26) / 52), 49'((ONE_Q48 + 26) / 53), 49'((ONE_Q48 + 27) / 54),
    49'((ONE_Q48 + 27) / 55), 49'((ONE_Q48 + 28) / 56), 49'((ONE_Q48 + 28) / 57),
    49'((ONE_Q48 + 29) / 58), 49'((ONE_Q48 + 29) / 59), 49'((ONE_Q48 + 30) / 60),
    49'((ONE_Q48 + 30) / 61), 49'((ONE_Q48 + 31) / 62), 49'((ONE_Q48 + 31) / 63)
  };

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_LOAD1, OP_MULX, OP_ADDP, OP_MULC,
    OP_MULD, OP_SUB, OP_MULR, OP_ADV, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       issue;
    logic [1:0] comp;
    logic [5:0] k;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
  } status_t;

endpackage

>>> hdl/ldp_mul.sv
`timescale 1ns / 1ps
module ldp_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [5:0]  shift,
  output logic        done,
  output logic [63:0] result,
  output logic        sat
);
  logic         run_r, pv_r, done_r, neg_r, sat_r;
  logic [63:0]  ua_r, ub_r, prod_r, res_r;
  logic [5:0]   s_r;
  logic [3:0]   mask_r;
  logic [1:0]   pos_r;
  logic [127:0] acc_r;
  logic [1:0]   idx;
  logic [31:0]  ah, bh;
  logic [63:0]  ma, mb, lim, mag;
  logic [127:0] q;
  logic         ov;

  assign ma  = a[63] ? (64'd0 - a) : a;
  assign mb  = b[63] ? (64'd0 - b) : b;
  assign idx = mask_r[0] ? 2'd0 : mask_r[1] ? 2'd1 : mask_r[2] ? 2'd2 : 2'd3;
  assign ah  = idx[1] ? ua_r[63:32] : ua_r[31:0];
  assign bh  = idx[0] ? ub_r[63:32] : ub_r[31:0];
  assign q   = acc_r >> s_r;
  assign lim = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  assign ov  = (|q[127:64]) || (q[63:0] > lim);
  assign mag = ov ? lim : q[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r   <= ma;
        ub_r   <= mb;
        neg_r  <= a[63] ^ b[63];
        s_r    <= shift;
        mask_r <= {(|ma[63:32]) & (|mb[63:32]), |ma[63:32], |mb[63:32], 1'b1};
        acc_r  <= '0;
        run_r  <= 1'b1;
        pv_r   <= 1'b0;
      end else if (run_r) begin
        if (mask_r != 4'd0) begin
          prod_r      <= ah * bh;
          pos_r       <= 2'(idx[1]) + 2'(idx[0]);
          mask_r[idx] <= 1'b0;
          pv_r        <= 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
        if (pv_r) begin
          acc_r <= acc_r + ({64'd0, prod_r} << {pos_r, 5'd0});
        end
        if (mask_r == 4'd0 && !pv_r) begin
          res_r  <= neg_r ? (64'd0 - mag) : mag;
          sat_r  <= ov;
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;
  assign sat    = sat_r;
endmodule

>>> hdl/ldp_datapath.sv
`timescale 1ns / 1ps
module ldp_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  ldp_pkg::cmd_t cmd,
  output ldp_pkg::status_t status,
  input  logic [31:0]   arg_x,
  output logic [5:0]    order_index,
  output logic [63:0]   poly_value,
  output logic [63:0]   first_deriv,
  output logic [63:0]   second_deriv,
  output logic          overflowed,
  output logic          last_of_run
);
  import ldp_pkg::*;

  logic [31:0] x_r;
  logic [63:0] p1_r [3];
  logic [63:0] p2_r [3];
  logic [63:0] nt_r [3];
  logic [63:0] t_r, u_r;
  logic        sat_r;
  logic [5:0]  oi_r;
  logic [63:0] op0_r, op1_r, op2_r;
  logic        ov_r, last_r;

  logic [63:0] ma, mb, mres, c_val, d_val, r_val, xe, add_a, add_b;
  logic [5:0]  msh;
  logic        mdone, msat, add_sub;
  logic [64:0] sum;
  logic        sum_ov;
  logic [63:0] sum_res;
  logic [1:0]  cprev;

  assign xe    = {{32{x_r[31]}}, x_r};
  assign c_val = 64'({cmd.k, 1'b0} - 7'd1);
  assign d_val = 64'(cmd.k - 6'd1);
  assign r_val = 64'(RECIP_ROM[cmd.k]);
  assign cprev = cmd.comp - 2'd1;

  always_comb begin
    ma  = t_r;
    mb  = c_val;
    msh = 6'd0;
    case (cmd.op)
      OP_MULX: begin
        ma  = xe;
        mb  = p1_r[cmd.comp];
        msh = SHIFT_X;
      end
      OP_MULD: begin
        ma = p2_r[cmd.comp];
        mb = d_val;
      end
      OP_MULR: begin
        mb  = r_val;
        msh = SHIFT_R;
      end
      default: begin
      end
    endcase
  end

  ldp_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.issue),
    .a      (ma),
    .b      (mb),
    .shift  (msh),
    .done   (mdone),
    .result (mres),
    .sat    (msat)
  );

  assign add_sub = (cmd.op == OP_SUB);
  assign add_a   = add_sub ? t_r : p1_r[cprev];
  assign add_b   = add_sub ? ~u_r : t_r;
  assign sum     = {add_a[63], add_a} + {add_b[63], add_b} + 65'(add_sub);
  assign sum_ov  = sum[64] != sum[63];
  assign sum_res = sum_ov ? (sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                          : sum[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_INIT: begin
          x_r   <= arg_x;
          sat_r <= 1'b0;
          p1_r  <= '{ONE_Q40, 64'd0, 64'd0};
          p2_r  <= '{64'd0, 64'd0, 64'd0};
        end
        OP_LOAD1: begin
          p2_r <= '{ONE_Q40, 64'd0, 64'd0};
          p1_r <= '{{{22{x_r[31]}}, x_r, 10'd0}, ONE_Q40, 64'd0};
        end
        OP_MULX, OP_MULC: begin
          if (mdone) begin
            t_r   <= mres;
            sat_r <= sat_r | msat;
          end
        end
        OP_MULD: begin
          if (mdone) begin
            u_r   <= mres;
            sat_r <= sat_r | msat;
          end
        end
        OP_MULR: begin
          if (mdone) begin
            nt_r[cmd.comp] <= mres;
            sat_r          <= sat_r | msat;
          end
        end
        OP_ADDP, OP_SUB: begin
          t_r   <= sum_res;
          sat_r <= sat_r | sum_ov;
        end
        OP_ADV: begin
          p2_r <= p1_r;
          p1_r <= nt_r;
        end
        OP_EMIT: begin
          oi_r   <= cmd.k;
          op0_r  <= p1_r[0];
          op1_r  <= p1_r[1];
          op2_r  <= p1_r[2];
          ov_r   <= sat_r;
          last_r <= cmd.last;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.mul_done = mdone;
  assign order_index  = oi_r;
  assign poly_value   = op0_r;
  assign first_deriv  = op1_r;
  assign second_deriv = op2_r;
  assign overflowed   = ov_r;
  assign last_of_run  = last_r;
endmodule

>>> hdl/ldp_ctrl.sv
`timescale 1ns / 1ps
module ldp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [5:0]       order_n,
  output logic             busy,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_emit_all_orders,
  output ldp_pkg::cmd_t    cmd,
  input  ldp_pkg::status_t status,
  output logic             out_valid
);
  import ldp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_LOAD1, S_MULX, S_WX, S_ADD1, S_ADD2, S_MULC, S_WC,
    S_MULD, S_WD, S_SUB, S_MULR, S_WR, S_ADV
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] k_r, k_nxt, n_r, n_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic       all_r, ov_nxt, out_valid_r;
  logic       at_end;

  assign at_end    = (k_r == n_r);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    comp_nxt  = comp_r;
    ov_nxt    = 1'b0;
    cmd       = '{op: OP_NONE, issue: 1'b0, comp: comp_r, k: k_r, last: at_end};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_INIT;
          n_nxt     = (order_n > MAX_ORDER) ? MAX_ORDER : order_n;
          k_nxt     = 6'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (all_r || at_end) begin
          cmd.op = OP_EMIT;
          ov_nxt = 1'b1;
        end
        if (at_end) begin
          state_nxt = S_IDLE;
        end else if (k_r == 6'd0) begin
          state_nxt = S_LOAD1;
        end else begin
          k_nxt     = k_r + 6'd1;
          comp_nxt  = 2'd0;
          state_nxt = S_MULX;
        end
      end
      S_LOAD1: begin
        cmd.op    = OP_LOAD1;
        k_nxt     = 6'd1;
        state_nxt = S_EMIT;
      end
      S_MULX: begin
        cmd.op    = OP_MULX;
        cmd.issue = 1'b1;
        state_nxt = S_WX;
      end
      S_WX: begin
        cmd.op = OP_MULX;
        if (status.mul_done) begin
          state_nxt = (comp_r == 2'd0) ? S_MULC : S_ADD1;
        end
      end
      S_ADD1: begin
        cmd.op    = OP_ADDP;
        state_nxt = (comp_r == 2'd2) ? S_ADD2 : S_MULC;
      end
      S_ADD2: begin
        cmd.op    = OP_ADDP;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        cmd.op    = OP_MULC;
        cmd.issue = 1'b1;
        state_nxt = S_WC;
      end
      S_WC: begin
        cmd.op = OP_MULC;
        if (status.mul_done) begin
          state_nxt = S_MULD;
        end
      end
      S_MULD: begin
        cmd.op    = OP_MULD;
        cmd.issue = 1'b1;
        state_nxt = S_WD;
      end
      S_WD: begin
        cmd.op = OP_MULD;
        if (status.mul_done) begin
          state_nxt = S_SUB;
        end
      end
      S_SUB: begin
        cmd.op    = OP_SUB;
        state_nxt = S_MULR;
      end
      S_MULR: begin
        cmd.op    = OP_MULR;
        cmd.issue = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.op = OP_MULR;
        if (status.mul_done) begin
          if (comp_r == 2'd2) begin
            state_nxt = S_ADV;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = S_MULX;
          end
        end
      end
      S_ADV: begin
        cmd.op    = OP_ADV;
        state_nxt = S_EMIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 6'd0;
      n_r         <= 6'd0;
      comp_r      <= 2'd0;
      all_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      comp_r      <= comp_nxt;
      out_valid_r <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        all_r <= cfg_emit_all_orders;
      end
    end
  end

  assign out_valid = out_valid_r;
endmodule

>>> hdl/legendre_poly_derivatives_core.sv
`timescale 1ns / 1ps
// Legendre polynomial P_k(x) with P'_k and P''_k, Q2.30 argument, Q24.40 results.
// Input: pulse start with in_arg_x and in_order_n while busy is low; the word is
// taken on that edge and busy stays high until the run is done.
// Config: cfg_emit_all_orders is written on cfg_valid && cfg_ready; cfg_ready is
// low while busy. 1 emits every order 0..n, 0 emits only order n. Reset value 0.
// Output: each result word is on the out_ ports for one cycle with out_valid high;
// out_last_of_run marks order n. The receiver cannot stall: every word must be
// taken in its cycle.
// Schedule: order 0 needs no arithmetic and order 1 only a load step. Each further
// order runs twelve products on one shared 32x32 multiplier, each taking longer
// for wider operands, plus add, subtract, update and emit steps.
// One word is in flight at a time; the next start is taken once busy falls.
// Reset (synchronous, rst_n low) returns to idle, clears the mode register and
// drops any run in progress.
module legendre_poly_derivatives_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_arg_x,
  input  logic [5:0]  in_order_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_emit_all_orders,
  output logic        out_valid,
  output logic [5:0]  out_order_index,
  output logic [63:0] out_poly_value,
  output logic [63:0] out_first_deriv,
  output logic [63:0] out_second_deriv,
  output logic        out_overflowed,
  output logic        out_last_of_run
);
  import ldp_pkg::*;

  cmd_t    cmd;
  status_t status;

  ldp_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .order_n             (in_order_n),
    .busy                (busy),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_emit_all_orders (cfg_emit_all_orders),
    .cmd                 (cmd),
    .status              (status),
    .out_valid           (out_valid)
  );

  ldp_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .arg_x        (in_arg_x),
    .order_index  (out_order_index),
    .poly_value   (out_poly_value),
    .first_deriv  (out_first_deriv),
    .second_deriv (out_second_deriv),
    .overflowed   (out_overflowed),
    .last_of_run  (out_last_of_run)
  );

  a_out_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result word outside a run");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy) else $error("run still busy after last word");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |=> !out_valid) else $error("word after last of run");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
endmodule
